>>> rtl/diphoton_mass_window_selector_core_assert.svh
// Assertion macros shared by the selector RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DIPHOTON_MASS_WINDOW_SELECTOR_CORE_ASSERT_SVH
`define DIPHOTON_MASS_WINDOW_SELECTOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication check
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// Next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/dmws_pkg.sv
// Shared types, constants and table builder for the diphoton selector.
// No dependencies; imported by all selector modules.
`timescale 1ns / 1ps

package dmws_pkg;

   // Field widths
   localparam int PT_W    = 17;
   localparam int ETA_W   = 14;
   localparam int PHI_W   = 13;
   localparam int EN_W    = 20;
   localparam int CUT_W   = 17;
   localparam int SEP_W   = 14;
   localparam int TOT_W   = 20;
   localparam int SUM_E_W = 23;
   localparam int DPHI_W  = 13;
   localparam int DETA_W  = 15;

   // Table geometry (largest supported depth)
   localparam int MAX_DEPTH   = 4096;
   localparam int ADDR_W      = 13;
   localparam int ENTRY_W     = 27;
   localparam int ROM_W       = ENTRY_W * (MAX_DEPTH + 1);
   localparam int NUM_LOOKUPS = 6;

   // Stream widths
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 24;

   // Fixed-point constants
   localparam longint unsigned PI_Q30     = 64'd3373259426;
   localparam longint unsigned INV_PI_Q23 = 64'd2670177;
   localparam int PHI_PI     = 3217;
   localparam int PHI_TWO_PI = 6434;

   // Register indexes
   localparam logic [1:0] REG_PAIR_PT_CUT    = 2'd0;
   localparam logic [1:0] REG_MASS_LOW       = 2'd1;
   localparam logic [1:0] REG_MASS_HIGH      = 2'd2;
   localparam logic [1:0] REG_MIN_SEPARATION = 2'd3;

   typedef struct packed {
      logic [CUT_W-1:0] pair_pt_cut;
      logic [CUT_W-1:0] mass_low;
      logic [CUT_W-1:0] mass_high;
      logic [SEP_W-1:0] min_separation;
   } cfg_type;

   // Classified event: lookup order is lead cos, sub cos, lead sin,
   // sub sin, lead sinh, sub sinh
   typedef struct packed {
      logic [PT_W-1:0]                     lead_pt;
      logic [PT_W-1:0]                     sub_pt;
      logic [NUM_LOOKUPS-1:0][ADDR_W-1:0]  addr;
      logic [NUM_LOOKUPS-1:0]              neg;
      logic [SUM_E_W-1:0]                  energy;
      logic [DPHI_W-1:0]                   dphi;
      logic [DETA_W-1:0]                   deta;
      logic                                last;
   } event_type;

   // Build the quarter-wave sine table (hyp = 0) or the sinh table (hyp = 1)
   // by the second-order recurrence; h36, hc and hcur0 are precomputed.
   function automatic logic [ROM_W-1:0] build_table(input int unsigned d,
                                                    input longint unsigned h36,
                                                    input longint unsigned hc,
                                                    input longint unsigned hcur0,
                                                    input logic hyp);
      logic [ROM_W-1:0]  res;
      longint unsigned   h2, c, h30, hprev, hcur, hs, hn, q, entry;
      longint            prevv, cur, s, nxt;
      int unsigned       k;
      res   = '0;
      h2    = (h36 * h36 + (64'd1 << 31)) >> 32;
      c     = h2 - (((h2 * h2 + (64'd1 << 39)) >> 40) / 12);
      h30   = (h36 + 64'd32) >> 6;
      prevv = 0;
      cur   = longint'(h30 - (((h2 * h30 + (64'd1 << 39)) >> 40) / 6));
      hprev = 0;
      hcur  = hcur0;
      for (k = 0; k <= d; k++) begin
         s  = (k == 0) ? 64'sd0 : cur;
         hs = (k == 0) ? 64'd0 : hcur;
         if (s < 0) s = 0;
         q = (unsigned'(s) + (64'd1 << 14)) >> 15;
         if (hyp) entry = (hs + 64'd256) >> 9;
         else     entry = (q > 64'd32768) ? 64'd32768 : q;
         res[k*ENTRY_W +: ENTRY_W] = entry[ENTRY_W-1:0];
         if (k != 0) begin
            nxt   = 2 * s - prevv -
                    longint'((c * unsigned'(s) + (64'd1 << 39)) >> 40);
            prevv = s;
            cur   = nxt;
            hn    = 2 * hs - hprev + ((hc * hs + (64'd1 << 35)) >> 36);
            hprev = hs;
            hcur  = hn;
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/diphoton_mass_window_selector_core.sv
// Diphoton mass-window selector: one event in, one pass flag and count out.
// Events are processed one at a time: the sequencer takes no new event from the
// queue until the last one is finished, since the single table read port and
// the shared 32x32 multiplier serve all six lookups and ten squares in turn.
// Reset: synchronous, active high; clears the queue, sequencer, pass counter,
// result valid and restores the cut registers to their defaults.
`timescale 1ns / 1ps

module diphoton_mass_window_selector_core #(
   parameter int COUNT_BITS       = 20,
   parameter int TRIG_TABLE_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   // lead_pt, lead_eta, lead_phi, lead_energy, sub_pt, sub_eta, sub_phi, sub_energy
   input  logic [dmws_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tlast,
   // event_passed, passed_total, zero fill
   output logic [dmws_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [3:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import dmws_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;
   logic       q_full, q_empty, q_push, q_pop;
   event_type  q_in, q_out;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pair_pt_cut    <= CUT_W'(5333);
         cfg_ff.mass_low       <= CUT_W'(960);
         cfg_ff.mass_high      <= CUT_W'(1040);
         cfg_ff.min_separation <= SEP_W'(154);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PAIR_PT_CUT:    cfg_ff.pair_pt_cut    <= csr_pwdata[CUT_W-1:0];
            REG_MASS_LOW:       cfg_ff.mass_low       <= csr_pwdata[CUT_W-1:0];
            REG_MASS_HIGH:      cfg_ff.mass_high      <= csr_pwdata[CUT_W-1:0];
            REG_MIN_SEPARATION: cfg_ff.min_separation <= csr_pwdata[SEP_W-1:0];
            default:            cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Register read back
   always_comb begin
      unique case (csr_idx)
         REG_PAIR_PT_CUT:    csr_prdata = 32'(cfg_ff.pair_pt_cut);
         REG_MASS_LOW:       csr_prdata = 32'(cfg_ff.mass_low);
         REG_MASS_HIGH:      csr_prdata = 32'(cfg_ff.mass_high);
         REG_MIN_SEPARATION: csr_prdata = 32'(cfg_ff.min_separation);
         default:            csr_prdata = '0;
      endcase
   end

   dmws_front #(
      .DEPTH (TRIG_TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_in)
   );

   dmws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   dmws_back #(
      .DEPTH      (TRIG_TABLE_DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_data     (q_out),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/dmws_front.sv
// Front end: accepts events and turns angles into table addresses and signs.
// Depends on dmws_pkg; feeds dmws_queue.
`timescale 1ns / 1ps

module dmws_front #(
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dmws_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic                              q_full,
   output logic                              push,
   output dmws_pkg::event_type               push_data
);
   import dmws_pkg::*;

   localparam int TB = $clog2(DEPTH);
   localparam int AW = $clog2(DEPTH + 1);
   localparam longint unsigned PHI_K = 64'(DEPTH) * INV_PI_Q23;

   logic [PT_W-1:0]  lead_pt, sub_pt;
   logic [ETA_W-1:0] lead_eta, sub_eta;
   logic [PHI_W-1:0] lead_phi, sub_phi;
   logic [EN_W-1:0]  lead_energy, sub_energy;

   logic [PHI_W:0]   lphi_mag, sphi_mag;
   logic [63:0]      lphi_prod, sphi_prod;
   logic [TB+1:0]    lsin_n, ssin_n, lcos_n, scos_n;
   logic [AW:0]      lsin_q, ssin_q, lcos_q, scos_q;
   logic [ETA_W:0]   leta_mag, seta_mag;
   logic [AW-1:0]    leta_k, seta_k;
   logic [ETA_W:0]   phi_diff;
   logic [ETA_W-1:0] dphi_raw;
   logic [ETA_W+1:0] dphi_wrap;
   logic [DPHI_W-1:0] dphi_mag;
   logic [DETA_W-1:0] deta_diff, deta_mag;

   // Map a step count below four quarters to table address and sign;
   // the largest phi magnitude stays under 3.6 quarters even for cos
   function automatic logic [AW:0] quarter(input logic [TB+1:0] n);
      logic [TB+1:0] r;
      logic [1:0]    qd;
      logic [AW-1:0] a;
      if (n >= (TB+2)'(3 * DEPTH)) begin
         qd = 2'd3;
         r  = n - (TB+2)'(3 * DEPTH);
      end else if (n >= (TB+2)'(2 * DEPTH)) begin
         qd = 2'd2;
         r  = n - (TB+2)'(2 * DEPTH);
      end else if (n >= (TB+2)'(DEPTH)) begin
         qd = 2'd1;
         r  = n - (TB+2)'(DEPTH);
      end else begin
         qd = 2'd0;
         r  = n;
      end
      a = qd[0] ? (AW'(DEPTH) - AW'(r)) : AW'(r);
      return {qd[1], a};
   endfunction

   // Eta to sinh table address, capped at the last entry
   function automatic logic [AW-1:0] eta_index(input logic [ETA_W:0] m);
      logic [27:0] kp;
      kp = 28'(m) * 28'(DEPTH) + 28'd4096;
      return (kp[27:13] > 15'(DEPTH)) ? AW'(DEPTH) : AW'(kp[27:13]);
   endfunction

   // Unpack the request
   assign lead_pt     = req_tdata[16:0];
   assign lead_eta    = req_tdata[30:17];
   assign lead_phi    = req_tdata[43:31];
   assign lead_energy = req_tdata[63:44];
   assign sub_pt      = req_tdata[80:64];
   assign sub_eta     = req_tdata[94:81];
   assign sub_phi     = req_tdata[107:95];
   assign sub_energy  = req_tdata[127:108];

   assign req_tready = !q_full && !reset;
   assign push       = req_tvalid && req_tready;

   // Phi magnitude to quarter-wave steps
   always_comb begin
      lphi_mag  = lead_phi[PHI_W-1] ? (PHI_W+1)'(~{1'b1, lead_phi} + 1'b1)
                                    : {1'b0, lead_phi};
      sphi_mag  = sub_phi[PHI_W-1] ? (PHI_W+1)'(~{1'b1, sub_phi} + 1'b1)
                                   : {1'b0, sub_phi};
      lphi_prod = 64'(lphi_mag) * PHI_K + (64'd1 << 31);
      sphi_prod = 64'(sphi_mag) * PHI_K + (64'd1 << 31);
      lsin_n    = lphi_prod[32 +: TB+2];
      ssin_n    = sphi_prod[32 +: TB+2];
      lcos_n    = lsin_n + (TB+2)'(DEPTH);
      scos_n    = ssin_n + (TB+2)'(DEPTH);
      lsin_q    = quarter(lsin_n);
      ssin_q    = quarter(ssin_n);
      lcos_q    = quarter(lcos_n);
      scos_q    = quarter(scos_n);
   end

   // Eta magnitude to sinh address
   always_comb begin
      leta_mag = lead_eta[ETA_W-1] ? (ETA_W+1)'(~{1'b1, lead_eta} + 1'b1)
                                   : {1'b0, lead_eta};
      seta_mag = sub_eta[ETA_W-1] ? (ETA_W+1)'(~{1'b1, sub_eta} + 1'b1)
                                  : {1'b0, sub_eta};
      leta_k   = eta_index(leta_mag);
      seta_k   = eta_index(seta_mag);
   end

   // Wrapped phi distance and eta distance, as magnitudes
   always_comb begin
      phi_diff  = {lead_phi[PHI_W-1], lead_phi[PHI_W-1], lead_phi}
                - {sub_phi[PHI_W-1], sub_phi[PHI_W-1], sub_phi};
      dphi_raw  = phi_diff[ETA_W] ? ETA_W'(~phi_diff + 1'b1) : ETA_W'(phi_diff);
      dphi_wrap = (ETA_W+2)'(PHI_TWO_PI) - (ETA_W+2)'(dphi_raw);
      if (dphi_raw >= ETA_W'(PHI_PI))
         dphi_mag = dphi_wrap[ETA_W+1] ? DPHI_W'(~dphi_wrap + 1'b1) : DPHI_W'(dphi_wrap);
      else
         dphi_mag = DPHI_W'(dphi_raw);
      deta_diff = {lead_eta[ETA_W-1], lead_eta} - {sub_eta[ETA_W-1], sub_eta};
      deta_mag  = deta_diff[DETA_W-1] ? DETA_W'(~deta_diff + 1'b1) : deta_diff;
   end

   // Assemble the classified event
   always_comb begin
      push_data.lead_pt = lead_pt;
      push_data.sub_pt  = sub_pt;
      push_data.addr[0] = ADDR_W'(lcos_q[AW-1:0]);
      push_data.addr[1] = ADDR_W'(scos_q[AW-1:0]);
      push_data.addr[2] = ADDR_W'(lsin_q[AW-1:0]);
      push_data.addr[3] = ADDR_W'(ssin_q[AW-1:0]);
      push_data.addr[4] = ADDR_W'(leta_k);
      push_data.addr[5] = ADDR_W'(seta_k);
      push_data.neg[0]  = lcos_q[AW];
      push_data.neg[1]  = scos_q[AW];
      push_data.neg[2]  = lsin_q[AW] ^ lead_phi[PHI_W-1];
      push_data.neg[3]  = ssin_q[AW] ^ sub_phi[PHI_W-1];
      push_data.neg[4]  = lead_eta[ETA_W-1];
      push_data.neg[5]  = sub_eta[ETA_W-1];
      push_data.energy  = SUM_E_W'({(EN_W+1)'(lead_energy) + (EN_W+1)'(sub_energy), 2'b00});
      push_data.dphi    = dphi_mag;
      push_data.deta    = deta_mag;
      push_data.last    = req_tlast;
   end

endmodule

>>> rtl/dmws_queue.sv
// Two-entry queue of classified events between front and back end.
// Depends on dmws_pkg.
`timescale 1ns / 1ps

module dmws_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dmws_pkg::event_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output dmws_pkg::event_type  pop_data,
   output logic                 empty
);
   import dmws_pkg::*;

   event_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> rtl/dmws_back.sv
// Back end: table lookups, four-vector sums, squared tests and pass counter.
// Depends on dmws_pkg and the assertion macro header; drains dmws_queue.
`timescale 1ns / 1ps

module dmws_back #(
   parameter int DEPTH      = 1024,
   parameter int COUNT_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dmws_pkg::cfg_type                 cfg,
   input  logic                              q_empty,
   input  dmws_pkg::event_type               q_data,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dmws_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import dmws_pkg::*;

`include "diphoton_mass_window_selector_core_assert.svh"

   localparam int AW    = $clog2(DEPTH + 1);
   localparam int ACC_W = 46;
   localparam longint unsigned D2    = 64'(DEPTH) * 64'(DEPTH);
   localparam longint unsigned H36   = (PI_Q30 * 64 + 64'(DEPTH)) / (64'd2 * 64'(DEPTH));
   localparam longint unsigned HC    = ((64'd1 << 42) + D2 / 2) / D2
                                     + ((64'd1 << 48) + 6 * D2 * D2) / (12 * D2 * D2);
   localparam longint unsigned HCUR0 = ((64'd1 << 27) + 64'(DEPTH) / 2) / 64'(DEPTH)
                                     + ((64'd1 << 33) + 3 * D2 * 64'(DEPTH))
                                       / (6 * D2 * 64'(DEPTH));
   localparam logic [ROM_W-1:0] SIN_ROM  = build_table(DEPTH, H36, HC, HCUR0, 1'b0);
   localparam logic [ROM_W-1:0] SINH_ROM = build_table(DEPTH, H36, HC, HCUR0, 1'b1);
   localparam logic [TOT_W-1:0] TOT_MAX  = '1;

   // Step codes
   localparam logic [4:0] STEP_ROM_LAST    = 5'd5;
   localparam logic [4:0] STEP_MUL_FIRST   = 5'd1;
   localparam logic [4:0] STEP_MUL_LAST    = 5'd6;
   localparam logic [4:0] STEP_ACC_FIRST   = 5'd2;
   localparam logic [4:0] STEP_ACC_LAST    = 5'd7;
   localparam logic [4:0] STEP_SQ_PX       = 5'd8;
   localparam logic [4:0] STEP_SQ_PY       = 5'd9;
   localparam logic [4:0] STEP_SQ_PZ       = 5'd10;
   localparam logic [4:0] STEP_SQ_E        = 5'd11;
   localparam logic [4:0] STEP_SQ_CUT      = 5'd12;
   localparam logic [4:0] STEP_SQ_LO       = 5'd13;
   localparam logic [4:0] STEP_SQ_HI       = 5'd14;
   localparam logic [4:0] STEP_SQ_SEP      = 5'd15;
   localparam logic [4:0] STEP_SQ_DPHI     = 5'd16;
   localparam logic [4:0] STEP_SQ_DETA     = 5'd17;
   localparam logic [4:0] STEP_STORE_FIRST = 5'd9;
   localparam logic [4:0] STEP_STORE_LAST  = 5'd18;
   localparam logic [4:0] STEP_LAST        = 5'd19;

   event_type               ev_ff;
   logic                    busy_ff, busy_in;
   logic [4:0]              step_ff, step_in;
   logic [2:0]              rd_idx;
   logic [AW-1:0]           rd_addr;
   logic [ENTRY_W-1:0]      rom_q_ff;
   logic [31:0]             mul_a, mul_b;
   logic                    mul_neg;
   logic [2:0]              mul_j, acc_j;
   logic [63:0]             prod_ff;
   logic                    prod_neg_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] prod_signed;
   logic [3:0]              sq_idx;
   logic [63:0]             sq_ff [10];
   logic [31:0]             px, py, pz;
   logic [64:0]             pt2, p2, e2, cut2, lo2, hi2, sep2, dr2;
   logic                    pass;
   logic                    finish;
   logic                    out_free;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_next, cnt_in;
   logic [32:0]             cnt_wide;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_pass_ff;
   logic [TOT_W-1:0]        rsp_total_ff;
   logic                    rsp_last_ff;

   // Round a Q18 sum to Q5, ties away from zero, as a magnitude
   function automatic logic [31:0] round_q5(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] r;
      m = v[ACC_W-1] ? ACC_W'(~v + 1'b1) : ACC_W'(v);
      r = (m + ACC_W'(4096)) >> 13;
      return r[31:0];
   endfunction

   // Sequencer control
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = !busy_ff && !q_empty;
   assign finish   = busy_ff && (step_ff == STEP_LAST) && out_free;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff && step_ff != STEP_LAST) begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) ev_ff <= q_data;
   end

   // Table read, one lookup a step
   always_comb begin
      rd_idx  = (step_ff <= STEP_ROM_LAST) ? step_ff[2:0] : 3'd0;
      rd_addr = ev_ff.addr[rd_idx][AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (rd_idx >= 3'd4) rom_q_ff <= SINH_ROM[rd_addr*ENTRY_W +: ENTRY_W];
      else                rom_q_ff <= SIN_ROM[rd_addr*ENTRY_W +: ENTRY_W];
   end

   // Rounded momentum components
   always_comb begin
      px = round_q5(acc_ff[0]);
      py = round_q5(acc_ff[1]);
      pz = round_q5(acc_ff[2]);
   end

   // Select operands of the shared multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      mul_j   = step_ff[2:0] - 3'd1;
      unique case (step_ff) inside
         [STEP_MUL_FIRST:STEP_MUL_LAST]: begin
            mul_a   = mul_j[0] ? 32'(ev_ff.sub_pt) : 32'(ev_ff.lead_pt);
            mul_b   = 32'(rom_q_ff);
            mul_neg = (mul_j < 3'(NUM_LOOKUPS)) ? ev_ff.neg[mul_j] : 1'b0;
         end
         STEP_SQ_PX: begin
            mul_a = px;
            mul_b = px;
         end
         STEP_SQ_PY: begin
            mul_a = py;
            mul_b = py;
         end
         STEP_SQ_PZ: begin
            mul_a = pz;
            mul_b = pz;
         end
         STEP_SQ_E: begin
            mul_a = 32'(ev_ff.energy);
            mul_b = 32'(ev_ff.energy);
         end
         STEP_SQ_CUT: begin
            mul_a = 32'({cfg.pair_pt_cut, 2'b00});
            mul_b = 32'({cfg.pair_pt_cut, 2'b00});
         end
         STEP_SQ_LO: begin
            mul_a = 32'({cfg.mass_low, 2'b00});
            mul_b = 32'({cfg.mass_low, 2'b00});
         end
         STEP_SQ_HI: begin
            mul_a = 32'({cfg.mass_high, 2'b00});
            mul_b = 32'({cfg.mass_high, 2'b00});
         end
         STEP_SQ_SEP: begin
            mul_a = 32'(cfg.min_separation);
            mul_b = 32'(cfg.min_separation);
         end
         STEP_SQ_DPHI: begin
            mul_a = 32'(ev_ff.dphi);
            mul_b = 32'(ev_ff.dphi);
         end
         STEP_SQ_DETA: begin
            mul_a = 32'(ev_ff.deta);
            mul_b = 32'(ev_ff.deta);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= 64'(mul_a) * 64'(mul_b);
      prod_neg_ff <= mul_neg;
   end

   // Accumulate signed products into px, py, pz sums
   always_comb begin
      acc_j       = step_ff[2:0] - 3'd2;
      prod_signed = prod_neg_ff ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
      sq_idx      = 4'(step_ff - STEP_STORE_FIRST);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
         acc_ff[2] <= '0;
      end else if (busy_ff && step_ff >= STEP_ACC_FIRST && step_ff <= STEP_ACC_LAST) begin
         acc_ff[acc_j[2:1]] <= acc_ff[acc_j[2:1]] + prod_signed;
      end
   end

   // Keep each square
   always_ff @(posedge clock) begin
      if (busy_ff && step_ff >= STEP_STORE_FIRST && step_ff <= STEP_STORE_LAST)
         sq_ff[sq_idx] <= prod_ff;
   end

   // Selection tests on squares
   always_comb begin
      pt2  = 65'(sq_ff[0]) + 65'(sq_ff[1]);
      p2   = pt2 + 65'(sq_ff[2]);
      e2   = 65'(sq_ff[3]);
      cut2 = 65'(sq_ff[4]);
      lo2  = 65'(sq_ff[5]);
      hi2  = 65'(sq_ff[6]);
      sep2 = 65'(sq_ff[7]);
      dr2  = 65'(sq_ff[8]) + 65'(sq_ff[9]);
      pass = (pt2 >= cut2) && (e2 > p2 + lo2) && (e2 < p2 + hi2) && (dr2 >= sep2);
   end

   // Saturating pass counter, cleared after the last event of a set
   always_comb begin
      cnt_next = cnt_ff + COUNT_BITS'(pass && (cnt_ff != '1));
      cnt_wide = 33'(cnt_next);
      cnt_in   = cnt_ff;
      if (finish) cnt_in = ev_ff.last ? '0 : cnt_next;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pass_ff  <= pass;
         rsp_total_ff <= (cnt_wide > 33'(TOT_MAX)) ? TOT_MAX : cnt_wide[TOT_W-1:0];
         rsp_last_ff  <= ev_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_total_ff, rsp_pass_ff});
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_IMPL(a_pop_when_idle, clock, reset, q_pop, !busy_ff)
   `ASSERT_IMPL(a_step_range, clock, reset, busy_ff, step_ff <= STEP_LAST)
   `ASSERT_NEXT(a_clear_after_set, clock, reset, finish && ev_ff.last, cnt_ff == '0)
   `ASSERT_NEXT(a_hold_last_step, clock, reset, busy_ff && step_ff == STEP_LAST && !finish, busy_ff && step_ff == STEP_LAST)

endmodule

>>> verif/tb.sv
// Self-checking testbench for diphoton_mass_window_selector_core.
// Depends on rtl/dmws_pkg.sv and the core RTL; drives the request stream and the APB-style
// register port, and checks every result against an internal predictor or a hand-typed one.
`timescale 1ns / 1ps

module tb;
   import dmws_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int CNT_MAX   = (1 << 20) - 1;
   localparam int WDOG_MAX  = 4000;
   localparam int DRAIN_CYC = 40;

   typedef struct {
      logic [PT_W-1:0]         lpt;
      logic signed [ETA_W-1:0] leta;
      logic signed [PHI_W-1:0] lphi;
      logic [EN_W-1:0]         le;
      logic [PT_W-1:0]         spt;
      logic signed [ETA_W-1:0] seta;
      logic signed [PHI_W-1:0] sphi;
      logic [EN_W-1:0]         se;
      logic                    last;
   } photon_pair_type;

   typedef struct {
      logic            passed;
      logic [TOT_W-1:0] total;
      logic            done;
   } selection_type;

   // Directed row: event plus an optional hand-typed result
   typedef struct {
      photon_pair_type ev;
      bit              typed;
      selection_type   res;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tlast = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   rsp_tlast;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [3:0]             csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   diphoton_mass_window_selector_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor state
   longint        sin_q15 [0:DEPTH];
   longint        sinh_q15[0:DEPTH];
   longint        cut_pt, win_lo, win_hi, min_dr;
   longint        pass_count;
   selection_type expected_sel[$];
   int            errors;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            running;
   int            quiet_cycles;

   // Fill the quarter-wave sine and the sinh tables by integer recurrence
   function automatic void fill_tables();
      longint unsigned d, d2, h36, h2, c, h30, hc, hcur, hprev, hs, hn, q;
      longint          prv, cur, s, nxt;
      d     = DEPTH;
      d2    = d * d;
      h36   = (PI_Q30 * 64 + d) / (2 * d);
      h2    = (h36 * h36 + (64'd1 << 31)) >> 32;
      c     = h2 - (((h2 * h2 + (64'd1 << 39)) >> 40) / 12);
      h30   = (h36 + 32) >> 6;
      prv   = 0;
      cur   = longint'(h30 - (((h2 * h30 + (64'd1 << 39)) >> 40) / 6));
      hc    = ((64'd1 << 42) + d2 / 2) / d2 + ((64'd1 << 48) + 6 * d2 * d2) / (12 * d2 * d2);
      hprev = 0;
      hcur  = ((64'd1 << 27) + d / 2) / d + ((64'd1 << 33) + 3 * d2 * d) / (6 * d2 * d);
      for (int k = 0; k <= DEPTH; k++) begin
         s  = (k == 0) ? 0 : cur;
         hs = (k == 0) ? 0 : hcur;
         if (s < 0) s = 0;
         q = (unsigned'(s) + (64'd1 << 14)) >> 15;
         sin_q15[k]  = (q > 32768) ? 32768 : longint'(q);
         sinh_q15[k] = longint'((hs + 256) >> 9);
         if (k != 0) begin
            nxt   = 2 * s - prv - longint'((c * unsigned'(s) + (64'd1 << 39)) >> 40);
            prv   = s;
            cur   = nxt;
            hn    = 2 * hs - hprev + ((hc * hs + (64'd1 << 35)) >> 36);
            hprev = hs;
            hcur  = hn;
         end
      end
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint quarter_sin(longint unsigned n);
      longint unsigned qd, r;
      longint          m;
      n  = n % (4 * DEPTH);
      qd = n / DEPTH;
      r  = n % DEPTH;
      m  = qd[0] ? sin_q15[DEPTH - r] : sin_q15[r];
      return (qd >= 2) ? -m : m;
   endfunction

   function automatic longint unsigned angle_steps(longint phi);
      return (unsigned'(abs64(phi)) * DEPTH * INV_PI_Q23 + (64'd1 << 31)) >> 32;
   endfunction

   function automatic longint sin_of(longint phi);
      longint v;
      v = quarter_sin(angle_steps(phi));
      return (phi < 0) ? -v : v;
   endfunction

   function automatic longint cos_of(longint phi);
      return quarter_sin(angle_steps(phi) + DEPTH);
   endfunction

   function automatic longint sinh_of(longint eta);
      longint k, v;
      k = (abs64(eta) * DEPTH + 4096) >>> 13;
      if (k > DEPTH) k = DEPTH;
      v = sinh_q15[k];
      return (eta < 0) ? -v : v;
   endfunction

   // Round a Q18 momentum sum to Q5, ties away from zero
   function automatic longint to_q5(longint v);
      longint m;
      m = (abs64(v) + 4096) >>> 13;
      return (v < 0) ? -m : m;
   endfunction

   // Pair momentum components in Q5
   function automatic void pair_momentum(photon_pair_type ev, output longint px,
                                         output longint py, output longint pz);
      longint lp, sp;
      lp = longint'(ev.lpt);
      sp = longint'(ev.spt);
      px = abs64(to_q5(lp * cos_of(ev.lphi) + sp * cos_of(ev.sphi)));
      py = abs64(to_q5(lp * sin_of(ev.lphi) + sp * sin_of(ev.sphi)));
      pz = abs64(to_q5(lp * sinh_of(ev.leta) + sp * sinh_of(ev.seta)));
   endfunction

   // Apply the three selection tests and advance the pass counter
   function automatic selection_type select_event(photon_pair_type ev);
      selection_type r;
      longint        px, py, pz, pt2, p2, e, e2, dphi, deta, dr2;
      bit            ok;
      pair_momentum(ev, px, py, pz);
      pt2  = px * px + py * py;
      p2   = pt2 + pz * pz;
      e    = (longint'(ev.le) + longint'(ev.se)) * 4;
      e2   = e * e;
      dphi = abs64(longint'(ev.lphi) - longint'(ev.sphi));
      if (dphi >= PHI_PI) dphi = PHI_TWO_PI - dphi;
      deta = longint'(ev.leta) - longint'(ev.seta);
      dr2  = dphi * dphi + deta * deta;
      ok = (pt2 >= 16 * cut_pt * cut_pt) && (e2 > p2 + 16 * win_lo * win_lo) &&
           (e2 < p2 + 16 * win_hi * win_hi) && (dr2 >= min_dr * min_dr);
      if (ok && pass_count < CNT_MAX) pass_count++;
      r.passed = ok;
      r.total  = pass_count[TOT_W-1:0];
      r.done   = ev.last;
      if (ev.last) pass_count = 0;
      return r;
   endfunction

   // Build a well-formed event whose mass lands near a window edge or just above the low edge
   function automatic photon_pair_type near_window_event();
      photon_pair_type ev;
      longint          px, py, pz, m, esum;
      ev.lpt  = PT_W'($urandom_range(0, 1) ? $urandom_range(0, 131071)
                                           : $urandom_range(0, 8000));
      ev.spt  = PT_W'($urandom_range(0, 1) ? $urandom_range(0, 131071)
                                           : $urandom_range(0, 8000));
      ev.leta = ETA_W'($signed($urandom_range(0, 10240)) - 5120);
      ev.seta = ETA_W'($signed($urandom_range(0, 10240)) - 5120);
      ev.lphi = PHI_W'($signed($urandom_range(0, 6434)) - 3217);
      ev.sphi = PHI_W'($signed($urandom_range(0, 6434)) - 3217);
      ev.le   = '0;
      ev.se   = '0;
      ev.last = ($urandom_range(0, 15) == 0);
      pair_momentum(ev, px, py, pz);
      m = 4 * ($urandom_range(0, 1) ? (win_lo + $urandom_range(0, 4)) - 2
                                   : (win_hi + $urandom_range(0, 4)) - 2);
      if ($urandom_range(0, 2) == 0) m = 4 * (win_lo + $urandom_range(0, 200));
      if (m < 0) m = 0;
      esum = longint'($sqrt(real'(px * px + py * py + pz * pz + m * m))) / 4
             + $urandom_range(0, 2) - 1;
      if (esum < 0) esum = 0;
      if (esum > 2 * 1048575) esum = 2 * 1048575;
      ev.le = EN_W'(esum / 2);
      ev.se = EN_W'(esum - esum / 2);
      return ev;
   endfunction

   // Any bit pattern in every field
   function automatic photon_pair_type raw_event();
      photon_pair_type ev;
      ev.lpt  = PT_W'($urandom);
      ev.leta = ETA_W'($urandom);
      ev.lphi = PHI_W'($urandom);
      ev.le   = EN_W'($urandom);
      ev.spt  = PT_W'($urandom);
      ev.seta = ETA_W'($urandom);
      ev.sphi = PHI_W'($urandom);
      ev.se   = EN_W'($urandom);
      ev.last = 1'($urandom_range(0, 1));
      return ev;
   endfunction

   task automatic report(string what, longint got, longint exp);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
      errors++;
   endtask

   // Register write: setup cycle, then access cycle
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_PAIR_PT_CUT:    cut_pt = value[CUT_W-1:0];
         REG_MASS_LOW:       win_lo = value[CUT_W-1:0];
         REG_MASS_HIGH:      win_hi = value[CUT_W-1:0];
         REG_MIN_SEPARATION: min_dr = value[SEP_W-1:0];
      endcase
   endtask

   task automatic set_cuts(int pt, int lo, int hi, int sep);
      write_reg(REG_PAIR_PT_CUT, pt);
      write_reg(REG_MASS_LOW, lo);
      write_reg(REG_MASS_HIGH, hi);
      write_reg(REG_MIN_SEPARATION, sep);
   endtask

   // Hold one event on the request stream until it transfers
   task automatic send_event(photon_pair_type ev, bit typed, selection_type res);
      selection_type pred;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tlast  <= ev.last;
      req_tdata  <= {ev.se, ev.sphi, ev.seta, ev.spt, ev.le, ev.lphi, ev.leta, ev.lpt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = select_event(ev);
      expected_sel = {expected_sel, (typed ? res : pred)};
   endtask

   // Wait for all results, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_sel.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Result check, receiver stalls and watchdog
   always @(posedge clock) begin
      selection_type exp_sel;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sel.size() == 0) begin
               report("unexpected result", rsp_tdata, 0);
            end else begin
               exp_sel = expected_sel.pop_front();
               if (rsp_tdata[0] !== exp_sel.passed)
                  report("event_passed", rsp_tdata[0], exp_sel.passed);
               if (rsp_tdata[TOT_W:1] !== exp_sel.total)
                  report("passed_total", rsp_tdata[TOT_W:1], exp_sel.total);
               if (rsp_tlast !== exp_sel.done)
                  report("set_done", rsp_tlast, exp_sel.done);
               if (rsp_tdata[RSP_DATA_W-1:TOT_W+1] !== '0)
                  report("zero fill", rsp_tdata[RSP_DATA_W-1:TOT_W+1], 0);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || !running)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   stim_row_type directed[11] = '{
      // all zero, ends the set: pt cut fails, count stays 0
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 1}, 1, '{0, 0, 1}},
      '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}},
      '{'{131071, 5120, 3217, 1048575, 131071, -5120, -3217, 1048575, 0}, 0, '{0, 0, 0}},
      '{'{131071, 8191, 4095, 1048575, 131071, -8192, -4096, 1048575, 0}, 0, '{0, 0, 0}},
      '{'{1, -8192, -4096, 0, 1, 8191, 4095, 0, 0}, 0, '{0, 0, 0}},
      // phi wrap across pi
      '{'{8000, 0, 3216, 1200, 8000, 0, -3216, 1200, 0}, 0, '{0, 0, 0}},
      '{'{30000, 100, 3217, 9000, 30000, -100, -3217, 9000, 0}, 0, '{0, 0, 0}},
      // same direction: zero separation
      '{'{40000, 200, 500, 5000, 40000, 200, 500, 5000, 0}, 0, '{0, 0, 0}},
      '{'{131071, 0, 0, 16384, 0, 0, 0, 16384, 1}, 0, '{0, 0, 0}},
      // mass squared negative
      '{'{50000, 0, 0, 0, 50000, 0, 1608, 0, 0}, 0, '{0, 0, 0}},
      '{'{6000, 5120, 1608, 1048575, 6000, -5120, -1608, 0, 1}, 0, '{0, 0, 0}}
   };

   initial begin
      int            n_items;
      selection_type none;
      none           = '{0, 0, 0};
      errors         = 0;
      quiet_cycles   = 0;
      running        = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_tables();
      cut_pt     = 5333;
      win_lo     = 960;
      win_hi     = 1040;
      min_dr     = 154;
      pass_count = 0;

      repeat (5) @(posedge clock);
      reset   <= 1'b0;
      running <= 1'b1;
      @(posedge clock);

      // Directed rows, then near-window events at reset cuts
      foreach (directed[i]) send_event(directed[i].ev, directed[i].typed, directed[i].res);
      repeat (12) send_event(near_window_event(), 0, none);
      drain();

      // Random phases: cut settings and flow-control pressure vary together
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_cuts(0, 0, 131071, 0);
            1: set_cuts(131071, 131071, 131071, 16383);
            2: set_cuts(5333, 960, 1040, 154);
            3: set_cuts(0, 1000, 1000, 0);
            4: set_cuts(800, 900, 1100, 16383);
            default: set_cuts($urandom_range(0, 8000), $urandom_range(0, 1500),
                              $urandom_range(800, 131071), $urandom_range(0, 3000));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         n_items = 150;
         for (int j = 0; j < n_items; j++)
            send_event(($urandom_range(0, 9) < 7) ? near_window_event() : raw_event(), 0, none);
         drain();
      end

      running <= 1'b0;
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/dmws_pkg.sv
rtl/dmws_front.sv
rtl/dmws_queue.sv
rtl/dmws_back.sv
rtl/diphoton_mass_window_selector_core.sv
verif/tb.sv
